>>> rtl/tup_pkg.sv
package tup_pkg;

    localparam int CHARS_W = 16;
    localparam int RADIX_W = 5;
    localparam int CFG_W   = 5;

    localparam logic [7:0] CHAR_ZERO = 8'h30;
    localparam logic [7:0] CHAR_NINE = 8'h39;
    localparam logic [7:0] CHAR_LC_A = 8'h61;
    localparam logic [7:0] CHAR_LC_F = 8'h66;
    localparam logic [7:0] CHAR_UC_A = 8'h41;
    localparam logic [7:0] CHAR_UC_F = 8'h46;
    localparam logic [7:0] CHAR_LC_X = 8'h78;
    localparam logic [7:0] CHAR_UC_X = 8'h58;
    localparam logic [3:0] HEX_TEN   = 4'ha;

    localparam logic [RADIX_W-1:0] BASE_AUTO = 5'd0;
    localparam logic [RADIX_W-1:0] RADIX_OCT = 5'd8;
    localparam logic [RADIX_W-1:0] RADIX_DEC = 5'd10;
    localparam logic [RADIX_W-1:0] RADIX_HEX = 5'd16;

    localparam logic REG_GIVEN_BASE  = 1'b0;
    localparam logic REG_PREFIX_RULE = 1'b1;

    typedef struct packed {
        logic [RADIX_W-1:0] given_base;
        logic               prefix_rule;
    } cfg_t;

    typedef enum logic [3:0] {
        PH_IDLE   = 4'b0001,
        PH_ZERO   = 4'b0010,
        PH_ZEROX  = 4'b0100,
        PH_DIGITS = 4'b1000
    } phase_t;

    // bit 4: character is a hex digit, bits 3:0: its value
    function automatic logic [4:0] hex_digit(input logic [7:0] c);
        logic [4:0] r;
        r = 5'd0;
        if (c >= CHAR_ZERO && c <= CHAR_NINE) begin
            r = {1'b1, 4'(c - CHAR_ZERO)};
        end else if (c >= CHAR_LC_A && c <= CHAR_LC_F) begin
            r = {1'b1, 4'(c - CHAR_LC_A) + HEX_TEN};
        end else if (c >= CHAR_UC_A && c <= CHAR_UC_F) begin
            r = {1'b1, 4'(c - CHAR_UC_A) + HEX_TEN};
        end
        return r;
    endfunction

endpackage

>>> rtl/tup_core.sv
module tup_core #(
    parameter int VALUE_BITS = 64,
    parameter int COUNT_BITS = 16
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  tup_pkg::cfg_t                cfg,
    input  logic                         step_fire,
    input  logic [7:0]                   char_in,
    input  logic                         start_flag,
    output logic                         emit,
    output logic [VALUE_BITS-1:0]        res_number,
    output logic [tup_pkg::CHARS_W-1:0]  res_chars,
    output logic [tup_pkg::RADIX_W-1:0]  res_radix
);
    import tup_pkg::*;

    phase_t                phase_reg, phase_next;
    logic [RADIX_W-1:0]    radix_reg, radix_next;
    logic [VALUE_BITS-1:0] acc_reg, acc_next;
    logic [COUNT_BITS-1:0] cnt_reg, cnt_next;

    logic [4:0]            dig;
    logic                  is_x;
    logic                  start_zero;
    logic [RADIX_W-1:0]    start_radix;
    logic [RADIX_W-1:0]    tk_radix;
    logic [VALUE_BITS-1:0] tk_acc;
    logic [COUNT_BITS-1:0] tk_cnt;
    logic                  dig_ok;
    logic [VALUE_BITS-1:0] mac;
    logic [COUNT_BITS-1:0] cnt_inc;
    logic                  take;

    always_comb begin
        dig         = hex_digit(char_in);
        is_x        = (char_in == CHAR_LC_X) || (char_in == CHAR_UC_X);
        start_zero  = (char_in == CHAR_ZERO) &&
                      (cfg.given_base == BASE_AUTO || cfg.given_base == RADIX_HEX ||
                       cfg.prefix_rule);
        start_radix = (cfg.given_base != BASE_AUTO) ? cfg.given_base :
                      (start_zero ? RADIX_OCT : RADIX_DEC);
        tk_radix    = start_flag ? start_radix : radix_reg;
        tk_acc      = start_flag ? '0 : acc_reg;
        tk_cnt      = start_flag ? '0 : cnt_reg;
        dig_ok      = dig[4] && (5'(dig[3:0]) < tk_radix);
        mac         = tk_acc * VALUE_BITS'(tk_radix) + VALUE_BITS'(dig[3:0]);
        cnt_inc     = (tk_cnt == '1) ? tk_cnt : tk_cnt + 1'b1;
    end

    always_comb begin
        phase_next = phase_reg;
        radix_next = radix_reg;
        acc_next   = acc_reg;
        cnt_next   = cnt_reg;
        emit       = 1'b0;
        res_number = tk_acc;
        res_chars  = CHARS_W'(tk_cnt);
        res_radix  = tk_radix;
        take       = 1'b0;
        if (start_flag) begin
            acc_next   = '0;
            cnt_next   = '0;
            radix_next = start_radix;
            if (start_zero) begin
                cnt_next   = COUNT_BITS'(1);
                phase_next = PH_ZERO;
            end else begin
                take = 1'b1;
            end
        end else begin
            case (phase_reg)
                PH_ZERO: begin
                    if (is_x) begin
                        if (cfg.prefix_rule) begin
                            radix_next = RADIX_HEX;
                            cnt_next   = COUNT_BITS'(2);
                            phase_next = PH_DIGITS;
                        end else if (cfg.given_base == RADIX_HEX) begin
                            cnt_next   = COUNT_BITS'(2);
                            phase_next = PH_DIGITS;
                        end else begin
                            phase_next = PH_ZEROX;
                        end
                    end else begin
                        take = 1'b1;
                    end
                end
                PH_ZEROX: begin
                    if (dig[4]) begin
                        radix_next = RADIX_HEX;
                        acc_next   = VALUE_BITS'(dig[3:0]);
                        cnt_next   = COUNT_BITS'(3);
                        phase_next = PH_DIGITS;
                    end else begin
                        // lone "0x": report the zero only
                        emit       = 1'b1;
                        res_number = '0;
                        res_chars  = CHARS_W'(1);
                        res_radix  = RADIX_OCT;
                        phase_next = PH_IDLE;
                    end
                end
                PH_DIGITS: take = 1'b1;
                default: ;
            endcase
        end
        if (take) begin
            phase_next = PH_DIGITS;
            if (dig_ok) begin
                acc_next = mac;
                cnt_next = cnt_inc;
            end else begin
                emit       = 1'b1;
                phase_next = PH_IDLE;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_IDLE;
            radix_reg <= '0;
            acc_reg   <= '0;
            cnt_reg   <= '0;
        end else if (step_fire) begin
            phase_reg <= phase_next;
            radix_reg <= radix_next;
            acc_reg   <= acc_next;
            cnt_reg   <= cnt_next;
        end
    end

endmodule

>>> rtl/text_to_unsigned_parser.sv
// Unsigned number parser for a character stream.
// Input beats carry one character on s_tdata and a start mark on s_tuser;
// a marked beat begins a new number and drops any unfinished one. The
// radix comes from given_base (register 0) or, when it is 0, from a "0" or
// "0x" prefix; prefix_rule (register 1) selects strict or forcing "0x".
// Registers are written via cfg_we/cfg_addr/cfg_wdata; the user must do so
// only while idle, which the block does not enforce. One result beat
// leaves on m_tdata when the first non-digit arrives, so every number must
// end with a terminator character. An accepted beat is held in the input
// register, its result in the output register. Throughput: one beat per
// cycle unless a result stalls, set by the single multiply-add on the
// accumulator feedback. Reset clears the configuration, the parse state
// and both valid flags. When m_tready is low with a result held, the input
// register fills and s_tready drops until the result beat is taken.
module text_to_unsigned_parser #(
    parameter int VALUE_BITS = 64,
    parameter int COUNT_BITS = 16
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_we,
    input  logic                          cfg_addr,
    input  logic [tup_pkg::CFG_W-1:0]     cfg_wdata,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [7:0]                    s_tdata,   // char_in
    input  logic                          s_tuser,   // start_flag
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // number, chars_used, radix_used, zero pad
    output logic [((VALUE_BITS + tup_pkg::CHARS_W + tup_pkg::RADIX_W + 7) / 8) * 8 - 1:0]
                                          m_tdata
);
    import tup_pkg::*;

    localparam int OUT_BITS = VALUE_BITS + CHARS_W + RADIX_W;

    cfg_t                  cfg_reg, cfg_next;

    logic                  in_valid_reg, in_valid_next;
    logic [7:0]            in_char_reg;
    logic                  in_start_reg;

    logic                  out_valid_reg, out_valid_next;
    logic [OUT_BITS-1:0]   out_data_reg;

    logic                  s_fire;
    logic                  step_fire;
    logic                  emit;
    logic [VALUE_BITS-1:0] res_number;
    logic [CHARS_W-1:0]    res_chars;
    logic [RADIX_W-1:0]    res_radix;

    tup_core #(
        .VALUE_BITS (VALUE_BITS),
        .COUNT_BITS (COUNT_BITS)
    ) u_core (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg        (cfg_reg),
        .step_fire  (step_fire),
        .char_in    (in_char_reg),
        .start_flag (in_start_reg),
        .emit       (emit),
        .res_number (res_number),
        .res_chars  (res_chars),
        .res_radix  (res_radix)
    );

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_we) begin
            case (cfg_addr)
                REG_GIVEN_BASE:  cfg_next.given_base  = cfg_wdata[RADIX_W-1:0];
                REG_PREFIX_RULE: cfg_next.prefix_rule = cfg_wdata[0];
                default: ;
            endcase
        end
    end

    // advance the held character only when a result has room
    assign step_fire = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready  = !in_valid_reg || step_fire;
    assign s_fire    = s_tvalid && s_tready;

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_fire) begin
            in_valid_next = 1'b1;
        end else if (step_fire) begin
            in_valid_next = 1'b0;
        end
        out_valid_next = out_valid_reg;
        if (step_fire && emit) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg       <= '0;
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            cfg_reg       <= cfg_next;
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            in_char_reg  <= s_tdata;
            in_start_reg <= s_tuser;
        end
        if (step_fire && emit) begin
            out_data_reg <= {res_radix, res_chars, res_number};
        end
    end

    assign m_tvalid = out_valid_reg;

    always_comb begin
        m_tdata               = '0;
        m_tdata[OUT_BITS-1:0] = out_data_reg;
    end

    a_emit_shows: assert property (@(posedge aclk) disable iff (!aresetn)
        (step_fire && emit) |=> m_tvalid)
        else $error("result beat lost after emit");

    a_stall_holds_core: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && !m_tready) |-> !step_fire)
        else $error("parser advanced while result stalled");

    a_radix_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[OUT_BITS-1:VALUE_BITS+CHARS_W] != BASE_AUTO))
        else $error("result carries zero radix");

endmodule
